// File: rtl/core/assert_macros.svh
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition implies consequence in the same cycle
`define ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, cond, cons)
`define ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

// File: rtl/core/bds_pkg.sv
// shared types, constants and rounding for the 2x2 box downsampler
`default_nettype none

package bds_pkg;

    localparam int PIXEL_W    = 8;
    localparam int PAIR_W     = 9;
    localparam int SUM_W      = 10;
    localparam int COLS_CFG_W = 12;
    localparam int ROWS_CFG_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 2'd1;

    localparam int RESET_COLUMNS = 640;
    localparam int RESET_ROWS    = 480;

    // request from the position logic to the line unit, one per beat
    typedef struct packed {
        logic wr;
        logic rd;
        logic last;
    } t_line_ctrl;

    // state of the line unit result stage
    typedef struct packed {
        logic valid;
        logic last;
    } t_line_stat;

    // round half up of sum / 4
    function automatic logic [PIXEL_W-1:0] round_quarter(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] biased;
        biased = sum + SUM_W'(2);
        return biased[SUM_W-1:2];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bds_line_unit.sv
// line store of pair sums with its read stage and block averaging
`default_nettype none

module bds_line_unit
    import bds_pkg::*;
#(
    parameter int LINE_DEPTH = 1024,
    parameter int IDX_W      = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_line_ctrl          i_ctrl,
    input  wire logic                i_advance,
    input  wire logic [IDX_W-1:0]    i_idx,
    input  wire logic [PAIR_W-1:0]   i_pair,
    output t_line_stat               o_stat,
    output logic      [PIXEL_W-1:0]  o_average
);

    logic [PAIR_W-1:0] r_line [LINE_DEPTH];
    logic [PAIR_W-1:0] r_rd_data;
    logic [PAIR_W-1:0] r_pair;
    logic              r_last;
    logic              r_valid;
    logic              n_valid;
    logic [SUM_W-1:0]  sum;

    // line store: even rows write, odd rows read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_line[i_idx] <= i_pair;
        end
        if (i_ctrl.rd) begin
            r_rd_data <= r_line[i_idx];
            r_pair    <= i_pair;
            r_last    <= i_ctrl.last;
        end
    end

    // result stage occupancy
    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.rd) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // four-pixel sum and rounded mean
    assign sum          = SUM_W'(r_rd_data) + SUM_W'(r_pair);
    assign o_average    = round_quarter(sum);
    assign o_stat.valid = r_valid;
    assign o_stat.last  = r_last;

endmodule

`default_nettype wire

// File: rtl/core/box_downsample_two_by_two_top.sv
// top level of the 2x2 box filter downsampler
// Takes 8-bit grey pixels of one image in raster order on the pixel channel
// (i_pixel_valid / o_pixel_stall / i_pixel_value) and returns the half-size
// image on the average channel (o_average_valid / i_average_stall), one
// rounded 2x2 mean per beat, with o_frame_last on the final one of a frame.
// Image size sits in two registers written over the cfg channel (index 0:
// columns, index 1: rows); write them only while no pixel is in flight.
// One pixel is accepted per clock while o_pixel_stall is low. A result passes
// from the pixel that closes its block through the synchronous line store read
// stage, then as a rounded sum into the output register. The line
// store has one write and one read port; even rows write pair sums, odd rows
// read them, so the two never touch the same entry in one cycle.
// When the receiver stalls, the output register and the read stage fill and
// the input then stalls; no beat is dropped. Reset clears the position
// counters and the pipeline and loads 640 x 480; the line store is not
// cleared and needs no sweep, as each odd row only reads what the even row
// before it wrote.
`default_nettype none

module box_downsample_two_by_two_top
    import bds_pkg::*;
#(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input pixels
    input  wire logic                  i_pixel_valid,
    output logic                       o_pixel_stall,
    input  wire logic [PIXEL_W-1:0]    i_pixel_value,
    // output averages
    output logic                       o_average_valid,
    input  wire logic                  i_average_stall,
    output logic      [PIXEL_W-1:0]    o_average_value,
    output logic                       o_frame_last
);

    localparam int COL_W      = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W      = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
    localparam int CSZ_W      = $clog2(MAX_COLUMNS + 1);
    localparam int RSZ_W      = $clog2(MAX_ROWS + 1);
    localparam int LINE_DEPTH = MAX_COLUMNS / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int RESET_COLS_CLAMPED =
        (RESET_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RESET_COLUMNS;
    localparam int RESET_ROWS_CLAMPED =
        (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS;

    logic [CSZ_W-1:0]      r_cols;
    logic [RSZ_W-1:0]      r_rows;
    logic [CSZ_W-1:0]      n_cols;
    logic [RSZ_W-1:0]      n_rows;
    logic [COLS_CFG_W-1:0] cfg_cols_raw;
    logic [ROWS_CFG_W-1:0] cfg_rows_raw;

    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      n_row;
    logic [PIXEL_W-1:0]    r_held;
    logic [CSZ_W-1:0]      col_ext;
    logic [RSZ_W-1:0]      row_ext;
    logic [CSZ_W-1:0]      even_cols;
    logic [RSZ_W-1:0]      even_rows;
    logic                  col_end;
    logic                  row_end;
    logic                  pair_col;
    logic                  in_accept;
    logic [PAIR_W-1:0]     pair;
    logic [IDX_W-1:0]      line_idx;

    t_line_ctrl            line_ctrl;
    t_line_stat            line_stat;
    logic                  line_advance;
    logic [PIXEL_W-1:0]    line_average;

    logic                  r_out_valid;
    logic [PIXEL_W-1:0]    r_out_value;
    logic                  r_out_last;
    logic                  n_out_valid;

    // configuration: zero counts as one, oversize saturates
    assign o_cfg_ready  = 1'b1;
    assign cfg_cols_raw = i_cfg_data[COLS_CFG_W-1:0];
    assign cfg_rows_raw = i_cfg_data[ROWS_CFG_W-1:0];

    always_comb begin
        priority if (cfg_cols_raw == '0) begin
            n_cols = CSZ_W'(1);
        end else if (32'(cfg_cols_raw) > 32'(MAX_COLUMNS)) begin
            n_cols = CSZ_W'(MAX_COLUMNS);
        end else begin
            n_cols = CSZ_W'(cfg_cols_raw);
        end
        priority if (cfg_rows_raw == '0) begin
            n_rows = RSZ_W'(1);
        end else if (32'(cfg_rows_raw) > 32'(MAX_ROWS)) begin
            n_rows = RSZ_W'(MAX_ROWS);
        end else begin
            n_rows = RSZ_W'(cfg_rows_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CSZ_W'(RESET_COLS_CLAMPED);
            r_rows <= RSZ_W'(RESET_ROWS_CLAMPED);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_IMAGE_COLUMNS: r_cols <= n_cols;
                REG_IMAGE_ROWS:    r_rows <= n_rows;
                default: ;
            endcase
        end
    end

    // position decode
    assign in_accept = i_pixel_valid && !o_pixel_stall;
    assign col_ext   = CSZ_W'(r_col);
    assign row_ext   = RSZ_W'(r_row);
    assign even_cols = {r_cols[CSZ_W-1:1], 1'b0};
    assign even_rows = {r_rows[RSZ_W-1:1], 1'b0};
    assign pair_col  = r_col[0] && (col_ext < even_cols);
    assign col_end   = (col_ext + CSZ_W'(1)) >= r_cols;
    assign row_end   = (row_ext + RSZ_W'(1)) >= r_rows;
    assign pair      = PAIR_W'(r_held) + PAIR_W'(i_pixel_value);
    assign line_idx  = IDX_W'(r_col >> 1);

    always_comb begin
        line_ctrl.wr   = in_accept && pair_col && !r_row[0];
        line_ctrl.rd   = in_accept && pair_col && r_row[0] && (row_ext < even_rows);
        line_ctrl.last = (row_ext == even_rows - RSZ_W'(1))
                      && (col_ext == even_cols - CSZ_W'(1));
    end

    // column and row counters wrap at the configured size
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0]) begin
                r_held <= i_pixel_value;
            end
        end
    end

    // line store and averaging
    bds_line_unit #(
        .LINE_DEPTH (LINE_DEPTH),
        .IDX_W      (IDX_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (line_ctrl),
        .i_advance (line_advance),
        .i_idx     (line_idx),
        .i_pair    (pair),
        .o_stat    (line_stat),
        .o_average (line_average)
    );

    // output register; input stalls only when both stages hold a result
    assign line_advance  = line_stat.valid && (!r_out_valid || !i_average_stall);
    assign o_pixel_stall = line_stat.valid && r_out_valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (line_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_average_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_advance) begin
            r_out_value <= line_average;
            r_out_last  <= line_stat.last;
        end
    end

    assign o_average_valid = r_out_valid;
    assign o_average_value = r_out_value;
    assign o_frame_last    = r_out_last;

    // checks
    `include "assert_macros.svh"

    `ASSERT_NEXT(a_read_fills_stage, i_clk, i_rst_n, line_ctrl.rd, line_stat.valid)
    `ASSERT_NEXT(a_stage_to_empty_out, i_clk, i_rst_n, line_stat.valid && !r_out_valid, r_out_valid)
    `ASSERT_NEXT(a_stage_holds_on_stall, i_clk, i_rst_n, line_stat.valid && r_out_valid && i_average_stall, line_stat.valid && r_out_valid)

endmodule

`default_nettype wire

// File: tb/tb_box_downsample_two_by_two_top.sv
// self-checking testbench for the 2x2 box filter downsampler top level
module tb_box_downsample_two_by_two_top
    import bds_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLUMNS   = 2048;
    localparam int MAX_ROWS      = 4096;
    localparam int LINE_DEPTH    = MAX_COLUMNS / 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 1250;

    // index that maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] mean;
        logic               last;
    } t_block_mean;

    // tracks image position and line sums, queues the expected block means
    class mean_tracker;
        logic [COLS_CFG_W-1:0] columns_reg;
        logic [ROWS_CFG_W-1:0] rows_reg;
        logic [PAIR_W-1:0]     pair_line [LINE_DEPTH];
        logic [PIXEL_W-1:0]    held;
        int unsigned           col_pos;
        int unsigned           row_pos;
        int unsigned           taken;
        int unsigned           failures;
        t_block_mean           pending_means [$];

        function new();
            columns_reg = COLS_CFG_W'(RESET_COLUMNS);
            rows_reg    = ROWS_CFG_W'(RESET_ROWS);
            foreach (pair_line[i]) pair_line[i] = '0;
            held     = '0;
            col_pos  = 0;
            row_pos  = 0;
            taken    = 0;
            failures = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_COLUMNS) columns_reg = data[COLS_CFG_W-1:0];
            else if (idx == REG_IMAGE_ROWS) rows_reg = data[ROWS_CFG_W-1:0];
        endfunction

        function void take_pixel(logic [PIXEL_W-1:0] pix);
            int unsigned cols;
            int unsigned rows;
            int unsigned even_cols;
            int unsigned even_rows;
            int unsigned idx;
            logic [PAIR_W-1:0] pair;
            logic [SUM_W-1:0]  block_sum;
            logic [SUM_W-1:0]  biased;
            t_block_mean       r;
            cols      = clamp_size(columns_reg, MAX_COLUMNS);
            rows      = clamp_size(rows_reg, MAX_ROWS);
            even_cols = cols & ~32'd1;
            even_rows = rows & ~32'd1;
            idx       = (col_pos / 2) % LINE_DEPTH;
            taken++;

            // left pixel of a pair is held, right pixel completes the pair
            if (col_pos % 2 == 0) begin
                held = pix;
            end else if (col_pos < even_cols) begin
                pair = {1'b0, held} + {1'b0, pix};
                if (row_pos % 2 == 0) begin
                    pair_line[idx] = pair;
                end else if (row_pos < even_rows) begin
                    block_sum = {1'b0, pair_line[idx]} + {1'b0, pair};
                    biased    = block_sum + SUM_W'(2);
                    r.mean    = biased[SUM_W-1:2];
                    r.last    = (row_pos == even_rows - 1) && (col_pos == even_cols - 1);
                    pending_means.push_back(r);
                end
            end

            // raster advance with wrap at row and frame end
            if (col_pos + 1 >= cols) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void check_mean(logic [PIXEL_W-1:0] value, logic last);
            t_block_mean want;
            if (pending_means.size() == 0) begin
                $display("%0t: average beat %0d (last %0b) with none expected",
                         $time, value, last);
                failures++;
                return;
            end
            want = pending_means.pop_front();
            if (value !== want.mean) begin
                $display("%0t: average_value expected %0d actual %0d",
                         $time, want.mean, value);
                failures++;
            end
            if (last !== want.last) begin
                $display("%0t: frame_last expected %0b actual %0b",
                         $time, want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_pixel_valid = 1'b0;
    logic                  o_pixel_stall;
    logic [PIXEL_W-1:0]    i_pixel_value = '0;
    logic                  o_average_valid;
    logic                  i_average_stall = 1'b0;
    logic [PIXEL_W-1:0]    o_average_value;
    logic                  o_frame_last;

    mean_tracker        tracker = new();
    int unsigned        burst_left = 0;
    int unsigned        stall_left = 0;
    int unsigned        stall_mode = 0;
    int unsigned        quiet_cycles = 0;
    logic [PIXEL_W-1:0] corner_pixels [$];

    box_downsample_two_by_two_top #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_stall  (o_pixel_stall),
        .i_pixel_value  (i_pixel_value),
        .o_average_valid(o_average_valid),
        .i_average_stall(i_average_stall),
        .o_average_value(o_average_value),
        .o_frame_last   (o_frame_last)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall pattern: free, light, heavy and solid stretches
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(4, 40) : $urandom_range(16, 200);
        end
        stall_left--;
        case (stall_mode)
            0: i_average_stall <= 1'b0;
            1: i_average_stall <= ($urandom_range(0, 3) == 0);
            2: i_average_stall <= ($urandom_range(0, 3) != 0);
            default: i_average_stall <= 1'b1;
        endcase
    end

    // output beat check
    always @(posedge i_clk) begin
        if (i_rst_n && o_average_valid && !i_average_stall)
            tracker.check_mean(o_average_value, o_frame_last);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_pixel_valid && !o_pixel_stall) || (o_average_valid && !i_average_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // wait until every expected mean is out, then let the pipeline drain
    task automatic settle_block();
        while (tracker.pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register beat on the cfg channel, after which valid drops and the channel idles
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_register(idx, CFG_DATA_W'(value));
        @(posedge i_clk);
    endtask

    task automatic set_size(input int unsigned cols, input int unsigned rows);
        settle_block();
        write_register(REG_IMAGE_COLUMNS, cols);
        write_register(REG_IMAGE_ROWS, rows);
    endtask

    // burst and gap pacing of the pixel sender, with an occasional full drain
    task automatic pace_sender();
        int unsigned gap;
        bit          drain;
        if (burst_left == 0) begin
            drain = ($urandom_range(0, 40) == 0);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (drain && gap == 0) gap = 1;
            if (gap != 0) begin
                i_pixel_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if (drain)
                    while (tracker.pending_means.size() != 0) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                     : $urandom_range(1, 48);
        end
        burst_left--;
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        i_pixel_valid <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_pixel_stall);
        tracker.take_pixel(pix);
    endtask

    // random pixels, then on until a row start on an even row so sizes may change
    task automatic send_run(input int unsigned target);
        int unsigned n;
        n = 0;
        while (n < target || tracker.col_pos != 0 || tracker.row_pos % 2 != 0) begin
            pace_sender();
            send_pixel(pick_pixel());
            n++;
        end
        i_pixel_valid <= 1'b0;
    endtask

    task automatic send_corner();
        foreach (corner_pixels[i]) begin
            pace_sender();
            send_pixel(corner_pixels[i]);
        end
        send_run(0);
    endtask

    initial begin
        int unsigned start_count;
        int unsigned cols;
        int unsigned rows;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // narrow image over the reset row count: two rows, no frame end
        write_register(REG_IMAGE_COLUMNS, 4);
        send_run(8);
        settle_block();
        write_register(REG_SPARE, 32'h1FFF);

        // full-scale block and a half-way sum that rounds up, no frame end
        set_size(4, 4);
        corner_pixels = {8'd255, 8'd255, 8'd0, 8'd1, 8'd255, 8'd255, 8'd0, 8'd1};
        send_corner();

        // zero sizes act as one column and one row: no output
        set_size(0, 0);
        corner_pixels = {8'd0, 8'd255, 8'd128};
        send_corner();

        // trailing odd column and odd row are dropped
        set_size(5, 3);
        corner_pixels = {8'd1, 8'd0, 8'd2, 8'd1, 8'd77,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd200,
                         8'd9, 8'd9, 8'd9, 8'd9, 8'd9};
        send_corner();

        // random small images, size changes mid-frame at even row starts
        start_count = tracker.taken;
        while (tracker.taken - start_count < RANDOM_PIXELS) begin
            cols = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            rows = $urandom_range(1, 9);
            if ($urandom_range(0, 15) == 0) cols = 0;
            if ($urandom_range(0, 15) == 0) rows = 0;
            set_size(cols, rows);
            send_run($urandom_range(1, 160));
        end

        settle_block();
        if (tracker.failures == 0 && tracker.pending_means.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bds_pkg.sv
rtl/core/bds_line_unit.sv
rtl/core/box_downsample_two_by_two_top.sv
tb/tb_box_downsample_two_by_two_top.sv
